// File: sv/ifr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ifr_pkg;

   localparam int CONTEXTS    = 64;
   localparam int INTERVALS   = 64;
   localparam int PAYLOAD_MAX = 65535;

   localparam int SLOT_W = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
   localparam int IV_W   = (INTERVALS > 1) ? $clog2(INTERVALS) : 1;
   localparam int IVC_W  = $clog2(INTERVALS + 1);
   localparam int IVA_W  = SLOT_W + IV_W;
   localparam int POS_W  = 17;

   localparam int OFF_SHIFT = 3;
   localparam int HDR_MAX   = 60;

   localparam logic [39:0] TIMEOUT_RESET = 40'd30000000000;

   typedef enum logic [2:0] {
      ST_PENDING   = 3'd0,
      ST_COMPLETE  = 3'd1,
      ST_MALFORMED = 3'd2,
      ST_FULL      = 3'd3,
      ST_OVERSIZE  = 3'd4,
      ST_SWEEP     = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      REQ_FRAG  = 2'd0,
      REQ_SWEEP = 2'd1,
      REQ_FLUSH = 2'd2,
      REQ_BAD   = 2'd3
   } req_kind_type;

   typedef struct packed {
      logic [31:0] src;
      logic [31:0] dst;
      logic [15:0] id;
      logic [7:0]  proto;
   } key_type;

   typedef struct packed {
      key_type           key;
      logic [63:0]       last;
      logic [5:0]        hdr;
      logic [1:0]        flags;
      logic [POS_W-1:0]  need;
      logic [IVC_W-1:0]  cnt;
   } ctx_type;

   typedef struct packed {
      logic [POS_W-1:0] lo;
      logic [POS_W-1:0] hi;
   } iv_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  slot;
      logic [16:0] dlen;
      logic [5:0]  hb;
      logic [6:0]  rel;
      logic [6:0]  inc;
   } rsp_type;

endpackage
`default_nettype wire

// File: sv/ifr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module ifr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                       clock,
   input  wire logic                       we,
   input  wire logic [$clog2(DEPTH)-1:0]   waddr,
   input  wire logic [WIDTH-1:0]           wdata,
   input  wire logic [$clog2(DEPTH)-1:0]   raddr,
   output logic      [WIDTH-1:0]           rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

// File: sv/ifr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ifr_ctrl import ifr_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [1:0]        req_type,
   input  wire logic [31:0]       req_src_addr,
   input  wire logic [31:0]       req_dst_addr,
   input  wire logic [15:0]       req_packet_id,
   input  wire logic [7:0]        req_protocol,
   input  wire logic [12:0]       req_offset_units,
   input  wire logic              req_more_fragments,
   input  wire logic [3:0]        req_header_words,
   input  wire logic [15:0]       req_packet_len,
   input  wire logic [63:0]       req_now_time,
   input  wire logic [39:0]       timeout,
   output logic                   rsp_valid,
   output rsp_type                rsp,
   output logic                   ctx_we,
   output logic [SLOT_W-1:0]      ctx_waddr,
   output ctx_type                ctx_wdata,
   output logic [SLOT_W-1:0]      ctx_raddr,
   input  wire ctx_type           ctx_rdata,
   output logic                   iv_we,
   output logic [IVA_W-1:0]       iv_waddr,
   output iv_type                 iv_wdata,
   output logic [IVA_W-1:0]       iv_raddr,
   input  wire iv_type            iv_rdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_LOAD, S_LOADW, S_UPDATE,
      S_MERGE1, S_MERGE2, S_RD0, S_RD0W, S_FIN
   } state_type;

   state_type          state_ff;
   req_kind_type       kind_ff;
   key_type            key_ff;
   logic [15:0]        off_ff;
   logic [5:0]         ihl_ff;
   logic [15:0]        len_ff;
   logic               mf_ff;
   logic [63:0]        now_ff;
   logic [SLOT_W:0]    idx_ff;
   logic               cval_ff;
   logic [SLOT_W-1:0]  cidx_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic               found_ff;
   logic               free_found_ff;
   logic [SLOT_W-1:0]  free_ff;
   logic [CONTEXTS-1:0] stale_ff;
   logic [CONTEXTS-1:0] valid_ff;
   logic [6:0]         rel_ff;
   logic [IVC_W-1:0]   rd_ff;
   logic [IVC_W-1:0]   kept_ff;
   logic [IV_W-1:0]    qidx_ff;
   logic [POS_W-1:0]   a_ff;
   logic [POS_W-1:0]   b_ff;
   iv_type             ivz_ff;
   ctx_type            ctx_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic               acc;
   logic               bad;
   logic [5:0]         in_ihl;
   logic [15:0]        plen;
   logic [POS_W-1:0]   end_pos;
   logic [63:0]        age;
   logic               stale;
   logic               key_hit;
   logic               cur_valid;
   logic               keep;
   logic               ge;
   logic               m2_done;
   ctx_type            upd;
   logic [5:0]         hb_upd;
   ctx_type            fin;
   logic               complete;
   logic [5:0]         hb_fin;
   logic [16:0]        dl;
   logic [IVC_W-1:0]   kk;
   logic [IV_W-1:0]    rd_lo;

   assign busy      = (state_ff != S_IDLE);
   assign acc       = start && !busy;
   assign in_ihl    = {req_header_words, 2'b00};
   assign bad       = (req_kind_type'(req_type) == REQ_BAD) ||
                      ((req_kind_type'(req_type) == REQ_FRAG) &&
                       (req_packet_len < {10'd0, in_ihl}));
   assign plen      = len_ff - {10'd0, ihl_ff};
   assign end_pos   = {1'b0, off_ff} + {1'b0, plen};
   assign age       = now_ff - ctx_rdata.last;
   assign stale     = age > {24'd0, timeout};
   assign key_hit   = (ctx_rdata.key == key_ff);
   assign cur_valid = valid_ff[cidx_ff];
   assign keep      = (b_ff < iv_rdata.lo) || (a_ff > iv_rdata.hi);
   assign ge        = (iv_rdata.lo >= a_ff);
   assign m2_done   = (cval_ff && !ge) || (!cval_ff && (rd_ff == '0));
   assign kk        = (kept_ff >= IVC_W'(INTERVALS)) ? IVC_W'(INTERVALS - 1) : kept_ff;
   assign rd_lo     = rd_ff[IV_W-1:0];

   always_comb begin
      upd      = ctx_ff;
      upd.last = now_ff;
      if ((off_ff == 16'd0) && !upd.flags[0]) begin
         upd.hdr      = (ihl_ff > 6'(HDR_MAX)) ? 6'(HDR_MAX) : ihl_ff;
         upd.flags[0] = 1'b1;
      end
      hb_upd = upd.flags[0] ? upd.hdr : 6'd0;
   end

   always_comb begin
      fin = ctx_ff;
      if (!mf_ff) begin
         fin.flags[1] = 1'b1;
         if (end_pos > fin.need) begin
            fin.need = end_pos;
         end
      end
      complete = (fin.flags == 2'b11) &&
                 ((fin.need == '0) ||
                  ((fin.cnt == IVC_W'(1)) && (ivz_ff.lo == '0) && (ivz_ff.hi >= fin.need)));
      hb_fin = fin.flags[0] ? fin.hdr : 6'd0;
      dl     = 17'({11'd0, hb_fin} + fin.need);
   end

   assign ctx_raddr = (state_ff == S_SCAN) ? idx_ff[SLOT_W-1:0] : slot_ff;
   assign ctx_we    = (state_ff == S_FIN) && !complete;
   assign ctx_waddr = slot_ff;
   assign ctx_wdata = fin;

   always_comb begin
      iv_raddr = {slot_ff, IV_W'(0)};
      iv_we    = 1'b0;
      iv_waddr = {slot_ff, kept_ff[IV_W-1:0]};
      iv_wdata = iv_rdata;
      case (state_ff)
         S_MERGE1: begin
            iv_raddr = {slot_ff, rd_lo};
            iv_we    = cval_ff && keep;
         end
         S_MERGE2: begin
            iv_raddr = {slot_ff, IV_W'(rd_ff - IVC_W'(1))};
            if (cval_ff) begin
               iv_we    = 1'b1;
               iv_waddr = {slot_ff, IV_W'(qidx_ff + IV_W'(1))};
               iv_wdata = ge ? iv_rdata : iv_type'{lo: a_ff, hi: b_ff};
            end else if (rd_ff == '0) begin
               iv_we    = 1'b1;
               iv_waddr = {slot_ff, IV_W'(0)};
               iv_wdata = '{lo: a_ff, hi: b_ff};
            end
         end
         default: begin
            iv_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cval_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (acc) begin
                  kind_ff <= req_kind_type'(req_type);
                  key_ff  <= '{src: req_src_addr, dst: req_dst_addr,
                               id: req_packet_id, proto: req_protocol};
                  off_ff  <= {req_offset_units, 3'b000};
                  ihl_ff  <= in_ihl;
                  len_ff  <= req_packet_len;
                  mf_ff   <= req_more_fragments;
                  now_ff  <= req_now_time;
                  if (bad) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_ff       <= '{ST_MALFORMED, 6'd0, 17'd0, 6'd0, 7'd0, 7'd0};
                  end else begin
                     state_ff      <= S_SCAN;
                     idx_ff        <= '0;
                     cval_ff       <= 1'b0;
                     rel_ff        <= '0;
                     found_ff      <= 1'b0;
                     free_found_ff <= 1'b0;
                     stale_ff      <= '0;
                  end
               end
            end
            S_SCAN: begin
               if (idx_ff != (SLOT_W+1)'(CONTEXTS)) begin
                  idx_ff  <= idx_ff + (SLOT_W+1)'(1);
                  cval_ff <= 1'b1;
                  cidx_ff <= idx_ff[SLOT_W-1:0];
               end else begin
                  cval_ff <= 1'b0;
               end
               if (cval_ff) begin
                  if (kind_ff != REQ_FRAG) begin
                     if (cur_valid && ((kind_ff == REQ_FLUSH) || stale)) begin
                        valid_ff[cidx_ff] <= 1'b0;
                        rel_ff            <= rel_ff + 7'd1;
                     end
                  end else begin
                     if (cur_valid && key_hit && !found_ff) begin
                        found_ff <= 1'b1;
                        slot_ff  <= cidx_ff;
                     end
                     if (cur_valid && stale) begin
                        stale_ff[cidx_ff] <= 1'b1;
                        rel_ff            <= rel_ff + 7'd1;
                     end
                     if ((!cur_valid || stale) && !free_found_ff) begin
                        free_found_ff <= 1'b1;
                        free_ff       <= cidx_ff;
                     end
                  end
               end else if (idx_ff == (SLOT_W+1)'(CONTEXTS)) begin
                  if (kind_ff != REQ_FRAG) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_ff       <= '{ST_SWEEP, 6'd0, 17'd0, 6'd0, rel_ff, rel_ff};
                     state_ff     <= S_IDLE;
                  end else if (found_ff) begin
                     rel_ff   <= '0;
                     state_ff <= S_LOAD;
                  end else begin
                     if (free_found_ff) begin
                        valid_ff <= (valid_ff & ~stale_ff) | (CONTEXTS'(1) << free_ff);
                        slot_ff  <= free_ff;
                        ctx_ff   <= '{key: key_ff, default: '0};
                        state_ff <= S_UPDATE;
                     end else begin
                        valid_ff     <= valid_ff & ~stale_ff;
                        rsp_valid_ff <= 1'b1;
                        rsp_ff       <= '{ST_FULL, 6'd0, 17'd0, 6'd0, rel_ff, rel_ff};
                        state_ff     <= S_IDLE;
                     end
                  end
               end
            end
            S_LOAD: begin
               state_ff <= S_LOADW;
            end
            S_LOADW: begin
               ctx_ff   <= ctx_rdata;
               state_ff <= S_UPDATE;
            end
            S_UPDATE: begin
               ctx_ff <= upd;
               if (end_pos > POS_W'(PAYLOAD_MAX)) begin
                  valid_ff[slot_ff] <= 1'b0;
                  rsp_valid_ff      <= 1'b1;
                  rsp_ff            <= '{ST_OVERSIZE, 6'(slot_ff), 17'd0, hb_upd,
                                         rel_ff, rel_ff};
                  state_ff          <= S_IDLE;
               end else if (plen != 16'd0) begin
                  a_ff     <= {1'b0, off_ff};
                  b_ff     <= end_pos;
                  rd_ff    <= '0;
                  kept_ff  <= '0;
                  cval_ff  <= 1'b0;
                  state_ff <= S_MERGE1;
               end else begin
                  state_ff <= S_RD0;
               end
            end
            S_MERGE1: begin
               if (rd_ff != ctx_ff.cnt) begin
                  rd_ff   <= rd_ff + IVC_W'(1);
                  cval_ff <= 1'b1;
                  qidx_ff <= rd_lo;
               end else begin
                  cval_ff <= 1'b0;
               end
               if (cval_ff) begin
                  if (keep) begin
                     kept_ff <= kept_ff + IVC_W'(1);
                  end else begin
                     if (iv_rdata.lo < a_ff) begin
                        a_ff <= iv_rdata.lo;
                     end
                     if (iv_rdata.hi > b_ff) begin
                        b_ff <= iv_rdata.hi;
                     end
                  end
               end else if (rd_ff == ctx_ff.cnt) begin
                  rd_ff    <= kk;
                  kept_ff  <= kk;
                  state_ff <= S_MERGE2;
               end
            end
            S_MERGE2: begin
               if (m2_done) begin
                  ctx_ff.cnt <= kept_ff + IVC_W'(1);
                  ivz_ff     <= '{lo: a_ff, hi: b_ff};
                  cval_ff    <= 1'b0;
                  state_ff   <= S_FIN;
               end else if (rd_ff != '0) begin
                  rd_ff   <= rd_ff - IVC_W'(1);
                  cval_ff <= 1'b1;
                  qidx_ff <= IV_W'(rd_ff - IVC_W'(1));
               end else begin
                  cval_ff <= 1'b0;
               end
            end
            S_RD0: begin
               state_ff <= S_RD0W;
            end
            S_RD0W: begin
               ivz_ff   <= iv_rdata;
               state_ff <= S_FIN;
            end
            S_FIN: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
               if (complete) begin
                  valid_ff[slot_ff] <= 1'b0;
                  rsp_ff <= '{ST_COMPLETE, 6'(slot_ff), dl, hb_fin, rel_ff, rel_ff};
               end else begin
                  rsp_ff <= '{ST_PENDING, 6'(slot_ff), 17'd0, hb_fin, rel_ff, rel_ff};
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

`ifndef NO_ASSERTIONS
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(busy || acc))
      else $error("result without a request");
   a_keep_behind: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MERGE1) |-> (kept_ff <= rd_ff))
      else $error("compaction overtook read pointer");
   a_free_done: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_FIN) && complete) |=> !valid_ff[$past(slot_ff)])
      else $error("completed slot still valid");
   a_dlen: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status == ST_COMPLETE)) |-> (rsp_ff.dlen >= 17'(rsp_ff.hb)))
      else $error("datagram shorter than header");
`endif

endmodule
`default_nettype wire

// File: sv/ipv4_fragment_reassembly_tracker_top.sv
// IPv4 fragment reassembly tracker.
// Request channel: a beat is taken on a rising edge with start high and busy
// low. req_type selects fragment arrival, stale expiry, flush, or malformed.
// Result channel: exactly one result per request, shown for one cycle with
// rsp_valid high; the receiver cannot stall, so it must take every beat.
// Config channel: csr_valid/csr_ready write timeout_ns (always ready); write
// it only while busy is low.
// Sequence: malformed requests answer in the cycle after accept. Every other
// request runs a pipelined scan of all context slots, then a fragment loads
// its context, updates it, merges its range in the interval memory (one pass
// over the n stored intervals plus one backward shift pass) and writes back.
// busy stays high throughout, one request at a time.
// The interval and context memories have one read and one write port each;
// the context scan and the interval passes set the rate.
// Reset: synchronous, clears all slot valid bits and loads the default
// timeout; memories need no clearing.
`timescale 1ns / 1ps
`default_nettype none
module ipv4_fragment_reassembly_tracker_top import ifr_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire logic [1:0]   req_type,
   input  wire logic [31:0]  req_src_addr,
   input  wire logic [31:0]  req_dst_addr,
   input  wire logic [15:0]  req_packet_id,
   input  wire logic [7:0]   req_protocol,
   input  wire logic [12:0]  req_offset_units,
   input  wire logic         req_more_fragments,
   input  wire logic [3:0]   req_header_words,
   input  wire logic [15:0]  req_packet_len,
   input  wire logic [63:0]  req_now_time,
   output logic              rsp_valid,
   output logic [2:0]        rsp_status,
   output logic [5:0]        rsp_slot,
   output logic [16:0]       rsp_datagram_len,
   output logic [5:0]        rsp_header_bytes,
   output logic [6:0]        rsp_released_count,
   output logic [6:0]        rsp_incomplete_count,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [39:0]  csr_wdata
);

   logic [39:0]        timeout_ff;
   rsp_type            rsp;
   logic               ctx_we;
   logic [SLOT_W-1:0]  ctx_waddr;
   ctx_type            ctx_wdata;
   logic [SLOT_W-1:0]  ctx_raddr;
   ctx_type            ctx_rdata;
   logic               iv_we;
   logic [IVA_W-1:0]   iv_waddr;
   iv_type             iv_wdata;
   logic [IVA_W-1:0]   iv_raddr;
   iv_type             iv_rdata;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_valid && csr_ready) begin
         timeout_ff <= csr_wdata;
      end
   end

   ifr_ram #(.WIDTH($bits(ctx_type)), .DEPTH(1 << SLOT_W)) u_ctx_ram (
      .clock (clock),
      .we    (ctx_we),
      .waddr (ctx_waddr),
      .wdata (ctx_wdata),
      .raddr (ctx_raddr),
      .rdata (ctx_rdata)
   );

   ifr_ram #(.WIDTH($bits(iv_type)), .DEPTH(1 << IVA_W)) u_iv_ram (
      .clock (clock),
      .we    (iv_we),
      .waddr (iv_waddr),
      .wdata (iv_wdata),
      .raddr (iv_raddr),
      .rdata (iv_rdata)
   );

   ifr_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_type           (req_type),
      .req_src_addr       (req_src_addr),
      .req_dst_addr       (req_dst_addr),
      .req_packet_id      (req_packet_id),
      .req_protocol       (req_protocol),
      .req_offset_units   (req_offset_units),
      .req_more_fragments (req_more_fragments),
      .req_header_words   (req_header_words),
      .req_packet_len     (req_packet_len),
      .req_now_time       (req_now_time),
      .timeout            (timeout_ff),
      .rsp_valid          (rsp_valid),
      .rsp                (rsp),
      .ctx_we             (ctx_we),
      .ctx_waddr          (ctx_waddr),
      .ctx_wdata          (ctx_wdata),
      .ctx_raddr          (ctx_raddr),
      .ctx_rdata          (ctx_rdata),
      .iv_we              (iv_we),
      .iv_waddr           (iv_waddr),
      .iv_wdata           (iv_wdata),
      .iv_raddr           (iv_raddr),
      .iv_rdata           (iv_rdata)
   );

   assign rsp_status           = rsp.status;
   assign rsp_slot             = rsp.slot;
   assign rsp_datagram_len     = rsp.dlen;
   assign rsp_header_bytes     = rsp.hb;
   assign rsp_released_count   = rsp.rel;
   assign rsp_incomplete_count = rsp.inc;

endmodule
`default_nettype wire
